// File: rtl/ep2cal_pkg.sv
// Types, constants and the microcode program of the epoch to calendar converter.
`default_nettype none

package ep2cal_pkg;

   // Last second of 2099-12-31 23:59:59; the four-year leap rule is exact up to here.
   localparam logic [31:0] LAST_VALID_SECOND = 32'd4102444799;

   // Base year, and the zero-based index of December.
   localparam logic [11:0] BASE_YEAR  = 12'd1970;
   localparam logic [3:0]  LAST_MONTH = 4'd11;

   // Days between 1970-01-01 (a Thursday) and the preceding Monday.
   localparam logic [16:0] WEEKDAY_OFFSET = 17'd3;

   // Width of the micro program counter.
   localparam int UPC_W = 5;
   typedef logic [UPC_W-1:0] upc_type;

   // Micro operations of the sequencer.
   typedef enum logic [3:0] {
      U_RANGE,
      U_DIV,
      U_REM,
      U_DAYS,
      U_QUAD,
      U_YEAR,
      U_MONTH,
      U_HOUR,
      U_MIN,
      U_WDAY,
      U_DONE
   } uop_type;

   // Divisor choices for the shared reciprocal divide steps.
   typedef enum logic [2:0] {
      D_DAY,
      D_QUAD,
      D_HOUR,
      D_MIN,
      D_WEEK
   } dsel_type;

   // One control word of the program.
   typedef struct packed {
      uop_type  op;
      dsel_type dsel;
      upc_type  target;
   } uword_type;

   // Sequencer state.
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   // Program addresses that are jumped to by name.
   localparam upc_type PC_DONE = 5'd18;
   localparam upc_type PC_LAST = 5'd18;

   // Builds one control word.
   function automatic uword_type uw(input uop_type op, input dsel_type dsel,
                                    input upc_type target);
      uword_type w;
      w.op     = op;
      w.dsel   = dsel;
      w.target = target;
      return w;
   endfunction

   // The program: split off days, then four-year blocks, years, months,
   // hours, minutes and finally the weekday. Each division is a quotient
   // step followed by a remainder step.
   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      case (pc)
         5'd0:    w = uw(U_RANGE, D_DAY,  PC_DONE);
         5'd1:    w = uw(U_DIV,   D_DAY,  PC_DONE);
         5'd2:    w = uw(U_REM,   D_DAY,  PC_DONE);
         5'd3:    w = uw(U_DAYS,  D_DAY,  PC_DONE);
         5'd4:    w = uw(U_DIV,   D_QUAD, PC_DONE);
         5'd5:    w = uw(U_REM,   D_QUAD, PC_DONE);
         5'd6:    w = uw(U_QUAD,  D_QUAD, PC_DONE);
         5'd7:    w = uw(U_YEAR,  D_QUAD, PC_DONE);
         5'd8:    w = uw(U_MONTH, D_QUAD, PC_DONE);
         5'd9:    w = uw(U_DIV,   D_HOUR, PC_DONE);
         5'd10:   w = uw(U_REM,   D_HOUR, PC_DONE);
         5'd11:   w = uw(U_HOUR,  D_HOUR, PC_DONE);
         5'd12:   w = uw(U_DIV,   D_MIN,  PC_DONE);
         5'd13:   w = uw(U_REM,   D_MIN,  PC_DONE);
         5'd14:   w = uw(U_MIN,   D_MIN,  PC_DONE);
         5'd15:   w = uw(U_DIV,   D_WEEK, PC_DONE);
         5'd16:   w = uw(U_REM,   D_WEEK, PC_DONE);
         5'd17:   w = uw(U_WDAY,  D_WEEK, PC_DONE);
         default: w = uw(U_DONE,  D_DAY,  PC_DONE);
      endcase
      return w;
   endfunction

   // Divisor value for each choice.
   function automatic logic [16:0] divisor(input dsel_type dsel);
      logic [16:0] d;
      case (dsel)
         D_DAY:   d = 17'd86400;
         D_QUAD:  d = 17'd1461;
         D_HOUR:  d = 17'd3600;
         D_MIN:   d = 17'd60;
         D_WEEK:  d = 17'd7;
         default: d = 17'd86400;
      endcase
      return d;
   endfunction

   // Power-of-two factor of each divisor, shifted off the dividend first.
   function automatic logic [2:0] recip_pre(input dsel_type dsel);
      logic [2:0] p;
      case (dsel)
         D_DAY:   p = 3'd7;
         D_QUAD:  p = 3'd0;
         D_HOUR:  p = 3'd4;
         D_MIN:   p = 3'd2;
         D_WEEK:  p = 3'd0;
         default: p = 3'd7;
      endcase
      return p;
   endfunction

   // Rounded-up reciprocal of the odd part of each divisor. Each one is exact
   // over the whole dividend range of its step.
   function automatic logic [25:0] recip_mul(input dsel_type dsel);
      logic [25:0] m;
      case (dsel)
         D_DAY:   m = 26'd50903317;
         D_QUAD:  m = 26'd45934;
         D_HOUR:  m = 26'd18642;
         D_MIN:   m = 26'd4370;
         D_WEEK:  m = 26'd74899;
         default: m = 26'd50903317;
      endcase
      return m;
   endfunction

   // Scale of each reciprocal as a power of two.
   function automatic logic [5:0] recip_post(input dsel_type dsel);
      logic [5:0] n;
      case (dsel)
         D_DAY:   n = 6'd35;
         D_QUAD:  n = 6'd26;
         D_HOUR:  n = 6'd22;
         D_MIN:   n = 6'd16;
         D_WEEK:  n = 6'd19;
         default: n = 6'd35;
      endcase
      return n;
   endfunction

   // Length of a zero-based month.
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: rtl/epoch_to_calendar_time_top.sv
// Top level of the epoch to calendar converter: microcoded sequencer and datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_epoch_seconds (32 bits)
//   rsp      out        rsp_valid/rsp_ready  year, month, day_of_month, hour, minute,
//                                            second, weekday, out_of_range
//
// From its transfer to the result register an item runs the fixed steps of the program,
// a year step and a month step that repeat while whole years or months remain. Each division
// by a constant is a reciprocal multiply step followed by a remainder step.
// An out-of-range item skips to the final step. A new item is taken only in idle.
// Reset is synchronous and clears the sequencer and the result valid flag.
// A new item is taken while the previous result waits in the output register;
// the program stalls in its last step only while that register is full and rsp_ready is low.
`default_nettype none

module epoch_to_calendar_time_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday,
   output logic        rsp_out_of_range
);
   import ep2cal_pkg::*;

   // Control registers.
   seq_state_type state_ff, state_in;
   upc_type       pc_ff, pc_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [31:0] acc_ff, acc_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] sec_ff, sec_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  dom_ff, dom_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  secw_ff, secw_in;
   logic [2:0]  wday_ff, wday_in;
   logic        oor_ff, oor_in;

   // Result register.
   logic [11:0] o_year_ff, o_year_in;
   logic [3:0]  o_mon_ff, o_mon_in;
   logic [4:0]  o_dom_ff, o_dom_in;
   logic [4:0]  o_hour_ff, o_hour_in;
   logic [5:0]  o_min_ff, o_min_in;
   logic [5:0]  o_sec_ff, o_sec_in;
   logic [2:0]  o_wday_ff, o_wday_in;
   logic        o_oor_ff, o_oor_in;

   // Decoded control word and shared arithmetic.
   uword_type   uword;
   logic [25:0] mul_x;
   logic [25:0] mul_m;
   logic [51:0] product;
   logic [32:0] quo_dv;
   logic        leap;
   logic [31:0] ylen;
   logic [31:0] mlen;

   assign uword   = ucode_rom(pc_ff);
   // Quotient by reciprocal: a 26 by 26 bit product scaled down by a power of two.
   assign mul_x   = 26'(acc_ff >> recip_pre(uword.dsel));
   assign mul_m   = recip_mul(uword.dsel);
   assign product = {26'd0, mul_x} * {26'd0, mul_m};
   // Quotient times divisor, taken off the dividend for the remainder.
   assign quo_dv  = {17'd0, quo_ff} * {16'd0, divisor(uword.dsel)};
   assign leap    = (year_ff[1:0] == 2'b00);
   assign ylen    = leap ? 32'd366 : 32'd365;
   assign mlen    = {27'd0, month_len(mon_ff, leap)};

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      days_in      = days_ff;
      sec_in       = sec_ff;
      year_in      = year_ff;
      mon_in       = mon_ff;
      dom_in       = dom_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      secw_in      = secw_ff;
      wday_in      = wday_ff;
      oor_in       = oor_ff;
      o_year_in    = o_year_ff;
      o_mon_in     = o_mon_ff;
      o_dom_in     = o_dom_ff;
      o_hour_in    = o_hour_ff;
      o_min_in     = o_min_ff;
      o_sec_in     = o_sec_ff;
      o_wday_in    = o_wday_ff;
      o_oor_in     = o_oor_ff;
      req_ready    = 1'b0;

      // A result transfer empties the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               acc_in   = req_epoch_seconds;
               pc_in    = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (uword.op)
               U_RANGE: begin
                  if (acc_ff > LAST_VALID_SECOND) begin
                     oor_in = 1'b1;
                     pc_in  = uword.target;
                  end else begin
                     oor_in = 1'b0;
                     pc_in  = pc_ff + upc_type'(1);
                  end
               end
               // Quotient of the accumulator by the selected divisor.
               U_DIV: begin
                  quo_in = 16'(product >> recip_post(uword.dsel));
                  pc_in  = pc_ff + upc_type'(1);
               end
               // The accumulator keeps the remainder.
               U_REM: begin
                  acc_in = 32'({1'b0, acc_ff} - quo_dv);
                  pc_in  = pc_ff + upc_type'(1);
               end
               U_DAYS: begin
                  days_in = quo_ff;
                  sec_in  = acc_ff[16:0];
                  acc_in  = {16'd0, quo_ff};
                  pc_in   = pc_ff + upc_type'(1);
               end
               // Any four consecutive years hold 1461 days.
               U_QUAD: begin
                  year_in = BASE_YEAR + {4'd0, quo_ff[5:0], 2'b00};
                  mon_in  = '0;
                  pc_in   = pc_ff + upc_type'(1);
               end
               U_YEAR: begin
                  if (acc_ff < ylen) begin
                     pc_in = pc_ff + upc_type'(1);
                  end else begin
                     acc_in  = acc_ff - ylen;
                     year_in = year_ff + 12'd1;
                  end
               end
               U_MONTH: begin
                  if (acc_ff < mlen || mon_ff == LAST_MONTH) begin
                     dom_in = acc_ff[4:0] + 5'd1;
                     acc_in = {15'd0, sec_ff};
                     pc_in  = pc_ff + upc_type'(1);
                  end else begin
                     acc_in = acc_ff - mlen;
                     mon_in = mon_ff + 4'd1;
                  end
               end
               U_HOUR: begin
                  hour_in = quo_ff[4:0];
                  pc_in   = pc_ff + upc_type'(1);
               end
               U_MIN: begin
                  min_in  = quo_ff[5:0];
                  secw_in = acc_ff[5:0];
                  acc_in  = {15'd0, {1'b0, days_ff} + WEEKDAY_OFFSET};
                  pc_in   = pc_ff + upc_type'(1);
               end
               U_WDAY: begin
                  wday_in = acc_ff[2:0];
                  pc_in   = pc_ff + upc_type'(1);
               end
               // Hand the result over once the output register is free.
               U_DONE: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                     o_oor_in     = oor_ff;
                     if (oor_ff) begin
                        o_year_in = '0;
                        o_mon_in  = '0;
                        o_dom_in  = '0;
                        o_hour_in = '0;
                        o_min_in  = '0;
                        o_sec_in  = '0;
                        o_wday_in = '0;
                     end else begin
                        o_year_in = year_ff;
                        o_mon_in  = mon_ff + 4'd1;
                        o_dom_in  = dom_ff;
                        o_hour_in = hour_ff;
                        o_min_in  = min_ff;
                        o_sec_in  = secw_ff;
                        o_wday_in = wday_ff;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      days_ff   <= days_in;
      sec_ff    <= sec_in;
      year_ff   <= year_in;
      mon_ff    <= mon_in;
      dom_ff    <= dom_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      secw_ff   <= secw_in;
      wday_ff   <= wday_in;
      oor_ff    <= oor_in;
      o_year_ff <= o_year_in;
      o_mon_ff  <= o_mon_in;
      o_dom_ff  <= o_dom_in;
      o_hour_ff <= o_hour_in;
      o_min_ff  <= o_min_in;
      o_sec_ff  <= o_sec_in;
      o_wday_ff <= o_wday_in;
      o_oor_ff  <= o_oor_in;
   end

   // Outputs.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = o_year_ff;
   assign rsp_month        = o_mon_ff;
   assign rsp_day_of_month = o_dom_ff;
   assign rsp_hour         = o_hour_ff;
   assign rsp_minute       = o_min_ff;
   assign rsp_second       = o_sec_ff;
   assign rsp_weekday      = o_wday_ff;
   assign rsp_out_of_range = o_oor_ff;

   // An out-of-range result carries all-zero fields.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_oor_ff) |->
         (o_year_ff == '0 && o_mon_ff == '0 && o_dom_ff == '0 && o_hour_ff == '0 &&
          o_min_ff == '0 && o_sec_ff == '0 && o_wday_ff == '0))
      else $error("out-of-range result has nonzero fields");

   // A valid date result lies within the calendar ranges.
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !o_oor_ff) |->
         (o_year_ff >= 12'd1970 && o_year_ff <= 12'd2099 &&
          o_mon_ff >= 4'd1 && o_mon_ff <= 4'd12 && o_dom_ff >= 5'd1 &&
          o_hour_ff < 5'd24 && o_min_ff < 6'd60 && o_sec_ff < 6'd60 && o_wday_ff < 3'd7))
      else $error("result field out of calendar range");

   // A new result appears only from the final program step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && uword.op == U_DONE))
      else $error("result loaded outside the final step");

   // The program counter never leaves the program.
   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= PC_LAST))
      else $error("micro program counter out of range");

endmodule

`default_nettype wire
